/* rtl/linear_probe_hash_table_assert.svh */
// Assertion macros shared by the table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that holds on every enabled clock edge.
`define LPH_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lph assertion failed");
// Consequent checked in the same cycle.
`define LPH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lph assertion failed");
// Consequent checked in the cycle after the antecedent.
`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lph assertion failed");
`else
`define LPH_ASSERT_HOLDS(label, clk, rst, prop)
`define LPH_ASSERT_NOW(label, clk, rst, ante, cons)
`define LPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/lph_pkg.sv */
package lph_pkg;

   // Field widths
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 64;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 2'd3;

   // 64-bit FNV-1a: prime is 2^40 + 0x1b3
   localparam logic [KEY_W-1:0] FNV_BASIS      = 64'hcbf2_9ce4_8422_2325;
   localparam logic [8:0]       FNV_MULT_LOW   = 9'h1b3;
   localparam int               FNV_MULT_SHIFT = 40;
   localparam int               HASH_ROUNDS    = 8;
   localparam int               BYTE_W         = 8;

   // Slot store strobes
   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic val_we;
   } tbl_ctrl_type;

endpackage

/* rtl/linear_probe_hash_table.sv */
// Key/value table with linear probing over TABLE_SLOTS slots (power of two).
// Request: req_command (get, put, remove), req_key, req_value_in; a
// transaction is taken at a clock edge with start high and busy low.
// Response: rsp_status and rsp_value_out, shown for one cycle with rsp_valid.
// Zero key, unused command or put into a full table: the response appears in
// the cycle after the request is taken.
// Other commands: FNV-1a hashing on one shared multiply-add unit, one key
// byte per round, then one slot read per cycle from the home slot upward,
// wrapping, until a slot matches (an empty one for put) or every slot has
// been compared; busy is high until the response and a new request can be
// taken in the cycle the response is shown.
// After reset the key store is cleared, one slot per cycle, with busy high.
// The receiver cannot stall: each response is taken in its strobe cycle.
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lph_pkg::CMD_W-1:0]     req_command,
   input  logic [lph_pkg::KEY_W-1:0]     req_key,
   input  logic [lph_pkg::VAL_W-1:0]     req_value_in,
   output logic                          rsp_valid,
   output logic [lph_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lph_pkg::VAL_W-1:0]     rsp_value_out
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_HASH  = 2'd2;
   localparam logic [1:0] S_PROBE = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [lph_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [lph_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [lph_pkg::VAL_W-1:0]       val_ff, val_in;
   logic [IDX_W-1:0]                addr_ff, addr_in;
   logic [IDX_W-1:0]                cmp_addr_ff, cmp_addr_in;
   logic [CNT_W-1:0]                iss_ff, iss_in;
   logic [CNT_W-1:0]                cmp_cnt_ff, cmp_cnt_in;
   logic                            vld_ff, vld_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lph_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [lph_pkg::VAL_W-1:0]       rsp_value_ff, rsp_value_in;

   logic                            accept;
   logic                            hash_start;
   logic                            hash_done;
   logic [IDX_W-1:0]                hash_slot;
   lph_pkg::tbl_ctrl_type           tbl_ctrl;
   logic [IDX_W-1:0]                wr_addr;
   logic [lph_pkg::KEY_W-1:0]       wr_key;
   logic [lph_pkg::VAL_W-1:0]       wr_val;
   logic [lph_pkg::KEY_W-1:0]       rd_key;
   logic [lph_pkg::VAL_W-1:0]       rd_val;
   logic                            hit;
   logic                            last_cmp;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Home slot hashing, key taken straight from the request port
   lph_hash #(
      .IDX_W (IDX_W)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   // Slot stores
   lph_table #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .ctrl    (tbl_ctrl),
      .rd_addr (addr_ff),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_val  (wr_val),
      .rd_key  (rd_key),
      .rd_val  (rd_val)
   );

   // Compare on the slot read in the previous cycle
   always_comb begin
      if (cmd_ff == lph_pkg::CMD_PUT) begin
         hit = vld_ff && (rd_key == '0);
      end else begin
         hit = vld_ff && (rd_key == key_ff);
      end
      last_cmp = vld_ff && (cmp_cnt_ff == CNT_W'(TABLE_SLOTS - 1));
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      addr_in       = addr_ff;
      cmp_addr_in   = cmp_addr_ff;
      iss_in        = iss_ff;
      cmp_cnt_in    = cmp_cnt_ff;
      vld_in        = 1'b0;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      hash_start    = 1'b0;
      tbl_ctrl      = '0;
      wr_addr       = cmp_addr_ff;
      wr_key        = key_ff;
      wr_val        = val_ff;

      unique case (state_ff)
         S_CLEAR: begin
            tbl_ctrl.key_we = 1'b1;
            wr_addr         = addr_ff;
            wr_key          = '0;
            addr_in         = addr_ff + IDX_W'(1);
            if (addr_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
               addr_in  = '0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in       = req_command;
               key_in       = req_key;
               val_in       = req_value_in;
               rsp_value_in = '0;
               if (req_command == lph_pkg::CMD_NONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lph_pkg::ST_OK;
               end else if (req_key == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lph_pkg::ST_ZERO_KEY;
               end else if ((req_command == lph_pkg::CMD_PUT) &&
                            (count_ff == CNT_W'(TABLE_SLOTS))) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lph_pkg::ST_FULL;
               end else begin
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in   = S_PROBE;
               addr_in    = hash_slot;
               iss_in     = '0;
               cmp_cnt_in = '0;
            end
         end
         S_PROBE: begin
            // read issue side
            tbl_ctrl.rd_en = (iss_ff != CNT_W'(TABLE_SLOTS));
            if (tbl_ctrl.rd_en) begin
               addr_in     = addr_ff + IDX_W'(1);
               iss_in      = iss_ff + CNT_W'(1);
               cmp_addr_in = addr_ff;
               vld_in      = 1'b1;
            end
            if (vld_ff) begin
               cmp_cnt_in = cmp_cnt_ff + CNT_W'(1);
            end
            // compare side
            if (hit) begin
               state_in      = S_IDLE;
               vld_in        = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = lph_pkg::ST_OK;
               if (cmd_ff == lph_pkg::CMD_PUT) begin
                  tbl_ctrl.key_we = 1'b1;
                  tbl_ctrl.val_we = 1'b1;
                  count_in        = count_ff + CNT_W'(1);
                  rsp_value_in    = '0;
               end else begin
                  rsp_value_in = rd_val;
                  if (cmd_ff == lph_pkg::CMD_REMOVE) begin
                     tbl_ctrl.key_we = 1'b1;
                     tbl_ctrl.val_we = 1'b1;
                     wr_key          = '0;
                     wr_val          = '0;
                     count_in        = count_ff - CNT_W'(1);
                  end
               end
            end else if (last_cmp) begin
               state_in      = S_IDLE;
               vld_in        = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               if (cmd_ff == lph_pkg::CMD_PUT) begin
                  rsp_status_in = lph_pkg::ST_FULL;
               end else begin
                  rsp_status_in = lph_pkg::ST_MISSING;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         iss_ff       <= '0;
         cmp_cnt_ff   <= '0;
         vld_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         iss_ff       <= iss_in;
         cmp_cnt_ff   <= cmp_cnt_in;
         vld_ff       <= vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cmp_addr_ff   <= cmp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

   // Checks
   `LPH_ASSERT_HOLDS(a_count_bound, clock, reset, (count_ff <= CNT_W'(TABLE_SLOTS)))
   `LPH_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, (state_ff == S_IDLE))
   `LPH_ASSERT_NOW(a_hash_in_hash, clock, reset, hash_done, (state_ff == S_HASH))
   `LPH_ASSERT_NEXT(a_zero_key, clock, reset,
      (accept && (req_key == '0) && (req_command != lph_pkg::CMD_NONE)),
      (rsp_valid && (rsp_status == lph_pkg::ST_ZERO_KEY)))
   `LPH_ASSERT_NEXT(a_full_fast, clock, reset,
      (accept && (req_key != '0) && (req_command == lph_pkg::CMD_PUT) &&
       (count_ff == CNT_W'(TABLE_SLOTS))),
      (rsp_valid && (rsp_status == lph_pkg::ST_FULL)))

endmodule

/* rtl/lph_hash.sv */
module lph_hash #(
   parameter int IDX_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lph_pkg::KEY_W-1:0]  key,
   output logic                       done,
   output logic [IDX_W-1:0]           slot
);

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [2:0]                 round_ff, round_in;
   logic [lph_pkg::KEY_W-1:0]  h_ff, h_in;
   logic [lph_pkg::KEY_W-1:0]  key_sh_ff, key_sh_in;
   logic [lph_pkg::KEY_W-1:0]  mix;
   logic [lph_pkg::KEY_W+8:0]  prod;
   logic [lph_pkg::KEY_W-1:0]  h_next;

   // One FNV-1a round: xor the low byte, multiply by 2^40 + 0x1b3
   always_comb begin
      mix    = h_ff ^ {{(lph_pkg::KEY_W-lph_pkg::BYTE_W){1'b0}},
                       key_sh_ff[lph_pkg::BYTE_W-1:0]};
      prod   = mix * lph_pkg::FNV_MULT_LOW;
      h_next = (mix << lph_pkg::FNV_MULT_SHIFT) + prod[lph_pkg::KEY_W-1:0];
   end

   // Round sequencer, least significant key byte first
   always_comb begin
      run_in    = run_ff;
      done_in   = 1'b0;
      round_in  = round_ff;
      h_in      = h_ff;
      key_sh_in = key_sh_ff;
      if (start) begin
         run_in    = 1'b1;
         round_in  = '0;
         h_in      = lph_pkg::FNV_BASIS;
         key_sh_in = key;
      end else if (run_ff) begin
         h_in      = h_next;
         key_sh_in = key_sh_ff >> lph_pkg::BYTE_W;
         round_in  = round_ff + 3'd1;
         if (round_ff == 3'(lph_pkg::HASH_ROUNDS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      round_ff  <= round_in;
      h_ff      <= h_in;
      key_sh_ff <= key_sh_in;
   end

   assign done = done_ff;
   assign slot = h_ff[IDX_W-1:0];

endmodule

/* rtl/lph_table.sv */
module lph_table #(
   parameter int TABLE_SLOTS = 64,
   parameter int IDX_W       = 6
) (
   input  logic                       clock,
   input  lph_pkg::tbl_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]           rd_addr,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [lph_pkg::KEY_W-1:0]  wr_key,
   input  logic [lph_pkg::VAL_W-1:0]  wr_val,
   output logic [lph_pkg::KEY_W-1:0]  rd_key,
   output logic [lph_pkg::VAL_W-1:0]  rd_val
);

   logic [lph_pkg::KEY_W-1:0] key_mem [TABLE_SLOTS];
   logic [lph_pkg::VAL_W-1:0] val_mem [TABLE_SLOTS];
   logic [lph_pkg::KEY_W-1:0] rd_key_ff;
   logic [lph_pkg::VAL_W-1:0] rd_val_ff;

   // Key store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctrl.rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   // Value store, read alongside the key
   always_ff @(posedge clock) begin
      if (ctrl.val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
      if (ctrl.rd_en) begin
         rd_val_ff <= val_mem[rd_addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_val = rd_val_ff;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_LEVEL = 16;
   localparam logic [lph_pkg::KEY_W-1:0] HASH_MULT = 64'd1099511628211;
   localparam logic [lph_pkg::KEY_W-1:0] ALL_ONES  = '1;

   typedef struct packed {
      logic [lph_pkg::STATUS_W-1:0] status;
      logic [lph_pkg::VAL_W-1:0]    value;
   } table_reply_type;

   // DUT ports, inputs all known from time zero
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [lph_pkg::CMD_W-1:0]    req_command = lph_pkg::CMD_NONE;
   logic [lph_pkg::KEY_W-1:0]    req_key = '0;
   logic [lph_pkg::VAL_W-1:0]    req_value_in = '0;
   logic                         rsp_valid;
   logic [lph_pkg::STATUS_W-1:0] rsp_status;
   logic [lph_pkg::VAL_W-1:0]    rsp_value_out;

   // Shadow copy of the table contents
   logic [lph_pkg::KEY_W-1:0] shadow_keys [TABLE_SLOTS];
   logic [lph_pkg::VAL_W-1:0] shadow_vals [TABLE_SLOTS];
   int                        occupied_slots = 0;
   bit                        draining = 1'b0;

   table_reply_type           pending_replies [$];
   logic [lph_pkg::KEY_W-1:0] hot_keys [8];

   int sender_idle_pct = 0;
   int cycle_count = 0;
   int txn_count = 0;
   int mismatch_count = 0;
   int stray_count = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   linear_probe_hash_table #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out)
   );

   // Clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  pending_replies.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // FNV-1a over the key bytes, low byte first, reduced to a slot number
   function automatic int home_slot_of(logic [lph_pkg::KEY_W-1:0] key);
      logic [lph_pkg::KEY_W-1:0] h;
      h = lph_pkg::FNV_BASIS;
      for (int b = 0; b < 8; b++) begin
         h = h ^ {56'd0, key[8*b +: 8]};
         h = h * HASH_MULT;
      end
      return int'(h % 64'(TABLE_SLOTS));
   endfunction

   // Apply one command to the shadow table and return the reply it produces
   function automatic table_reply_type apply_table_command(
         logic [lph_pkg::CMD_W-1:0] cmd,
         logic [lph_pkg::KEY_W-1:0] key,
         logic [lph_pkg::VAL_W-1:0] val);
      table_reply_type   reply;
      int                home;
      logic [SLOT_W-1:0] s;
      bit                done;
      reply.status = lph_pkg::ST_OK;
      reply.value  = '0;
      done         = 1'b0;
      if (cmd != lph_pkg::CMD_NONE) begin
         if (key == '0) begin
            reply.status = lph_pkg::ST_ZERO_KEY;
         end else begin
            home = home_slot_of(key);
            for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
               s = SLOT_W'((home + n) % TABLE_SLOTS);
               if (cmd == lph_pkg::CMD_PUT) begin
                  if (shadow_keys[s] == '0) begin
                     shadow_keys[s] = key;
                     shadow_vals[s] = val;
                     occupied_slots++;
                     done = 1'b1;
                  end
               end else if (shadow_keys[s] == key) begin
                  reply.value = shadow_vals[s];
                  if (cmd == lph_pkg::CMD_REMOVE) begin
                     shadow_keys[s] = '0;
                     shadow_vals[s] = '0;
                     occupied_slots--;
                  end
                  done = 1'b1;
               end
            end
            if (!done)
               reply.status = (cmd == lph_pkg::CMD_PUT) ? lph_pkg::ST_FULL
                                                        : lph_pkg::ST_MISSING;
         end
      end
      return reply;
   endfunction

   // Send one transaction: random idle first, then hold start until taken
   task automatic send_txn(logic [lph_pkg::CMD_W-1:0] cmd, logic [lph_pkg::KEY_W-1:0] key,
                           logic [lph_pkg::VAL_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= cmd;
      req_key      <= key;
      req_value_in <= val;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      pending_replies.push_back(apply_table_command(cmd, key, val));
      txn_count++;
   endtask

   // Compare every strobed reply with the oldest expected one
   always @(posedge clock) begin
      table_reply_type exp_reply;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            stray_count++;
            $display("reply with none expected at cycle %0d: status %0d value %h",
                     cycle_count, rsp_status, rsp_value_out);
         end else begin
            exp_reply = pending_replies.pop_front();
            status_seen[exp_reply.status]++;
            if (rsp_status !== exp_reply.status || rsp_value_out !== exp_reply.value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at cycle %0d: expected status %0d value %h, got %0d %h",
                           cycle_count, exp_reply.status, exp_reply.value,
                           rsp_status, rsp_value_out);
            end
         end
      end
   end

   function automatic logic [lph_pkg::KEY_W-1:0] fresh_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [lph_pkg::VAL_W-1:0] random_value();
      int r;
      r = $urandom_range(19);
      if (r == 0)
         return '0;
      else if (r == 1)
         return ALL_ONES;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SLOT_W-1:0] random_slot();
      return SLOT_W'($urandom_range(TABLE_SLOTS-1));
   endfunction

   // Extremes, each command, zero key, duplicates, missing keys, unused code
   task automatic test_directed();
      sender_idle_pct = 12;
      send_txn(lph_pkg::CMD_GET, '0, '0);
      send_txn(lph_pkg::CMD_PUT, '0, ALL_ONES);
      send_txn(lph_pkg::CMD_REMOVE, '0, '0);
      send_txn(lph_pkg::CMD_NONE, '0, '0);
      send_txn(lph_pkg::CMD_NONE, ALL_ONES, ALL_ONES);
      send_txn(lph_pkg::CMD_GET, ALL_ONES, '0);
      send_txn(lph_pkg::CMD_PUT, ALL_ONES, ALL_ONES);
      send_txn(lph_pkg::CMD_GET, ALL_ONES, '0);
      send_txn(lph_pkg::CMD_PUT, 64'd1, '0);
      send_txn(lph_pkg::CMD_GET, 64'd1, ALL_ONES);
      // duplicate key goes to the next free slot; first copy wins lookups
      send_txn(lph_pkg::CMD_PUT, 64'd1, 64'ha5a5_a5a5_a5a5_a5a5);
      send_txn(lph_pkg::CMD_REMOVE, 64'd1, '0);
      send_txn(lph_pkg::CMD_GET, 64'd1, '0);
      send_txn(lph_pkg::CMD_REMOVE, 64'd1, '0);
      send_txn(lph_pkg::CMD_REMOVE, 64'd1, '0);
      send_txn(lph_pkg::CMD_PUT, 64'h8000_0000_0000_0000, 64'h5a5a_5a5a_5a5a_5a5a);
      send_txn(lph_pkg::CMD_PUT, 64'h0123_4567_89ab_cdef, 64'd1);
      send_txn(lph_pkg::CMD_GET, 64'h8000_0000_0000_0000, '0);
      send_txn(lph_pkg::CMD_REMOVE, ALL_ONES, '0);
      send_txn(lph_pkg::CMD_GET, ALL_ONES, '0);
      send_txn(lph_pkg::CMD_NONE, fresh_key(), random_value());
   endtask

   // Fill every slot, hit the full case, probe a missing key, then empty it
   task automatic test_full_table();
      logic [SLOT_W-1:0] s;
      sender_idle_pct = 12;
      while (occupied_slots < TABLE_SLOTS)
         send_txn(lph_pkg::CMD_PUT, fresh_key(), random_value());
      send_txn(lph_pkg::CMD_PUT, fresh_key(), random_value());
      send_txn(lph_pkg::CMD_PUT, shadow_keys[random_slot()], random_value());
      send_txn(lph_pkg::CMD_GET, fresh_key(), '0);
      send_txn(lph_pkg::CMD_GET, shadow_keys[random_slot()], '0);
      while (occupied_slots > 0) begin
         s = random_slot();
         if (shadow_keys[s] != '0)
            send_txn(lph_pkg::CMD_REMOVE, shadow_keys[s], random_value());
      end
      send_txn(lph_pkg::CMD_REMOVE, fresh_key(), '0);
   endtask

   // Random commands over a mix of stored, hot, small and fresh keys;
   // occupancy swings between nearly empty and full
   task automatic test_random_mix(int count, int idle_pct);
      int                        r;
      int                        put_w;
      logic [lph_pkg::KEY_W-1:0] key;
      logic [lph_pkg::CMD_W-1:0] cmd;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         if (occupied_slots >= TABLE_SLOTS)
            draining = 1'b1;
         else if (occupied_slots < DRAIN_LEVEL)
            draining = 1'b0;
         put_w = draining ? 12 : 48;
         r = $urandom_range(99);
         if (r < 4)
            cmd = lph_pkg::CMD_NONE;
         else if (r < 4 + put_w)
            cmd = lph_pkg::CMD_PUT;
         else if (r < 4 + put_w + (96 - put_w) / 2)
            cmd = lph_pkg::CMD_GET;
         else
            cmd = lph_pkg::CMD_REMOVE;

         r = $urandom_range(99);
         if (r < 2)
            key = '0;
         else if (r < 45)
            key = shadow_keys[random_slot()];
         else if (r < 65)
            key = hot_keys[3'($urandom_range(7))];
         else if (r < 75)
            key = 64'($urandom_range(300, 1));
         else
            key = fresh_key();
         // empty slot picked: use a fresh key instead of an unintended zero
         if (r >= 2 && key == '0)
            key = fresh_key();
         send_txn(cmd, key, random_value());
      end
   endtask

   task automatic finish_run();
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (TABLE_SLOTS + 20) @(posedge clock);
      $display("%0d transactions: %0d ok, %0d missing, %0d full, %0d zero key",
               txn_count, status_seen[lph_pkg::ST_OK], status_seen[lph_pkg::ST_MISSING],
               status_seen[lph_pkg::ST_FULL], status_seen[lph_pkg::ST_ZERO_KEY]);
      $display("%0d mismatches, %0d stray replies", mismatch_count, stray_count);
      if (mismatch_count == 0 && stray_count == 0 && pending_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   endtask

   initial begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         shadow_keys[SLOT_W'(s)] = '0;
         shadow_vals[SLOT_W'(s)] = '0;
      end
      for (int i = 0; i < 7; i++)
         hot_keys[3'(i)] = fresh_key() | 64'd1;
      hot_keys[7] = ALL_ONES;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random_mix(350, 12);
      test_random_mix(350, 67);
      test_random_mix(350, 0);
      finish_run();
   end

endmodule
